[sv/rpi_pkg.sv]
// Package for the ray and plane intersection unit: widths, item types,
// register indexes and a shared arithmetic helper. Depends on nothing.
package rpi_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS = 16;
    localparam int PROD_WIDTH = 2 * COORD_WIDTH;
    localparam int SUM_WIDTH = PROD_WIDTH + 3;
    localparam int NUM_WIDTH = SUM_WIDTH + FRAC_BITS;
    localparam int REM_WIDTH = SUM_WIDTH + 1;
    localparam int HIT_WIDTH = PROD_WIDTH + 1;
    localparam int CFG_IDX_WIDTH = 3;

    localparam logic [CFG_IDX_WIDTH-1:0] REG_POINT_X = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_POINT_Y = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_POINT_Z = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_NORMAL_X = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_NORMAL_Y = 3'd4;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_NORMAL_Z = 3'd5;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    localparam coord_t UNIT_COORD = coord_t'(1) << FRAC_BITS;

    typedef struct packed {
        coord_t ray_origin_x;
        coord_t ray_origin_y;
        coord_t ray_origin_z;
        coord_t ray_dir_x;
        coord_t ray_dir_y;
        coord_t ray_dir_z;
    } ray_t;

    typedef struct packed {
        coord_t hit_x;
        coord_t hit_y;
        coord_t hit_z;
        logic   is_parallel;
        logic   is_behind;
        logic   overflowed;
    } result_t;

    typedef struct packed {
        coord_t point_x;
        coord_t point_y;
        coord_t point_z;
        coord_t normal_x;
        coord_t normal_y;
        coord_t normal_z;
    } plane_t;

    typedef struct packed {
        logic parallel;
        logic neg;
        logic big;
    } div_flags_t;

    typedef struct packed {
        logic [REM_WIDTH-1:0]   rem;
        logic [SUM_WIDTH-1:0]   dvsr;
        logic [COORD_WIDTH-1:0] quo;
    } div_state_t;

    function automatic logic signed [PROD_WIDTH-1:0] smul(coord_t a, coord_t b);
        smul = PROD_WIDTH'(a) * PROD_WIDTH'(b);
    endfunction

endpackage

[sv/ray_plane_intersection_unit.sv]
// Top level of the ray and plane intersection unit: plane registers and the
// pipeline. Depends on rpi_pkg, rpi_dot, rpi_div and rpi_hit.
//
// The unit takes one ray item in every clock cycle and never raises busy. Each item
// gives exactly one result, shown on result for one cycle with done high, in order,
// after passing the dot product registers (products, then sums), the divider's set-up
// register and quotient bit stages, and the hit point registers (ray parameter,
// direction products, result). The receiver cannot stall the unit, so it must take
// every result as it appears. Plane registers may be written only while no item is
// in flight.
module ray_plane_intersection_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  rpi_pkg::ray_t                       ray,
    output logic                                done,
    output rpi_pkg::result_t                    result,
    input  logic                                cfg_we,
    input  logic [rpi_pkg::CFG_IDX_WIDTH-1:0]   cfg_index,
    input  logic [rpi_pkg::COORD_WIDTH-1:0]     cfg_data
);

    rpi_pkg::plane_t                      plane_reg;
    logic                                 dot_valid;
    rpi_pkg::ray_t                        dot_ray;
    logic signed [rpi_pkg::SUM_WIDTH-1:0] dot_num;
    logic signed [rpi_pkg::SUM_WIDTH-1:0] dot_den;
    logic                                 div_valid;
    rpi_pkg::ray_t                        div_ray;
    rpi_pkg::div_flags_t                  div_flags;
    logic [rpi_pkg::COORD_WIDTH-1:0]      div_quo;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_reg.point_x  <= '0;
            plane_reg.point_y  <= '0;
            plane_reg.point_z  <= '0;
            plane_reg.normal_x <= rpi_pkg::UNIT_COORD;
            plane_reg.normal_y <= '0;
            plane_reg.normal_z <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rpi_pkg::REG_POINT_X:  plane_reg.point_x  <= cfg_data;
                rpi_pkg::REG_POINT_Y:  plane_reg.point_y  <= cfg_data;
                rpi_pkg::REG_POINT_Z:  plane_reg.point_z  <= cfg_data;
                rpi_pkg::REG_NORMAL_X: plane_reg.normal_x <= cfg_data;
                rpi_pkg::REG_NORMAL_Y: plane_reg.normal_y <= cfg_data;
                rpi_pkg::REG_NORMAL_Z: plane_reg.normal_z <= cfg_data;
                default: ;
            endcase
        end
    end

    rpi_dot u_dot (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .ray       (ray),
        .plane     (plane_reg),
        .out_valid (dot_valid),
        .ray_out   (dot_ray),
        .num       (dot_num),
        .den       (dot_den)
    );

    rpi_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dot_valid),
        .ray       (dot_ray),
        .num       (dot_num),
        .den       (dot_den),
        .out_valid (div_valid),
        .ray_out   (div_ray),
        .flags     (div_flags),
        .quo       (div_quo)
    );

    rpi_hit u_hit (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_valid),
        .ray       (div_ray),
        .flags     (div_flags),
        .quo       (div_quo),
        .out_valid (done),
        .result    (result)
    );

endmodule

[sv/rpi_dot.sv]
// Dot product stages: registered products, then the numerator and denominator sums.
// Depends on rpi_pkg.
module rpi_dot (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  rpi_pkg::ray_t                        ray,
    input  rpi_pkg::plane_t                      plane,
    output logic                                 out_valid,
    output rpi_pkg::ray_t                        ray_out,
    output logic signed [rpi_pkg::SUM_WIDTH-1:0] num,
    output logic signed [rpi_pkg::SUM_WIDTH-1:0] den
);

    logic                                  zero_normal;
    rpi_pkg::coord_t                       nx;
    logic                                  p1_valid_reg;
    rpi_pkg::ray_t                         p1_ray_reg;
    logic signed [rpi_pkg::PROD_WIDTH-1:0] prod_reg [0:8];
    logic signed [rpi_pkg::PROD_WIDTH-1:0] prod_next [0:8];
    logic                                  p2_valid_reg;
    rpi_pkg::ray_t                         p2_ray_reg;
    logic signed [rpi_pkg::SUM_WIDTH-1:0]  num_reg;
    logic signed [rpi_pkg::SUM_WIDTH-1:0]  den_reg;
    logic signed [rpi_pkg::SUM_WIDTH-1:0]  num_next;
    logic signed [rpi_pkg::SUM_WIDTH-1:0]  den_next;

    // An all-zero normal stands for the unit x axis.
    assign zero_normal = (plane.normal_x == '0) && (plane.normal_y == '0)
                         && (plane.normal_z == '0);
    assign nx = zero_normal ? rpi_pkg::UNIT_COORD : plane.normal_x;

    always_comb
    begin
        prod_next[0] = rpi_pkg::smul(nx, ray.ray_dir_x);
        prod_next[1] = rpi_pkg::smul(plane.normal_y, ray.ray_dir_y);
        prod_next[2] = rpi_pkg::smul(plane.normal_z, ray.ray_dir_z);
        prod_next[3] = rpi_pkg::smul(plane.point_x, nx);
        prod_next[4] = rpi_pkg::smul(plane.point_y, plane.normal_y);
        prod_next[5] = rpi_pkg::smul(plane.point_z, plane.normal_z);
        prod_next[6] = rpi_pkg::smul(nx, ray.ray_origin_x);
        prod_next[7] = rpi_pkg::smul(plane.normal_y, ray.ray_origin_y);
        prod_next[8] = rpi_pkg::smul(plane.normal_z, ray.ray_origin_z);
    end

    always_comb
    begin
        den_next = rpi_pkg::SUM_WIDTH'(prod_reg[0]) + rpi_pkg::SUM_WIDTH'(prod_reg[1])
                   + rpi_pkg::SUM_WIDTH'(prod_reg[2]);
        num_next = rpi_pkg::SUM_WIDTH'(prod_reg[3]) + rpi_pkg::SUM_WIDTH'(prod_reg[4])
                   + rpi_pkg::SUM_WIDTH'(prod_reg[5]) - rpi_pkg::SUM_WIDTH'(prod_reg[6])
                   - rpi_pkg::SUM_WIDTH'(prod_reg[7]) - rpi_pkg::SUM_WIDTH'(prod_reg[8]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= in_valid;
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_ray_reg <= ray;
        prod_reg   <= prod_next;
        p2_ray_reg <= p1_ray_reg;
        num_reg    <= num_next;
        den_reg    <= den_next;
    end

    assign out_valid = p2_valid_reg;
    assign ray_out   = p2_ray_reg;
    assign num       = num_reg;
    assign den       = den_reg;

endmodule

[sv/rpi_div.sv]
// Pipelined restoring divider for the ray parameter, one quotient bit per stage.
// Depends on rpi_pkg.
module rpi_div (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    input  rpi_pkg::ray_t                         ray,
    input  logic signed [rpi_pkg::SUM_WIDTH-1:0]  num,
    input  logic signed [rpi_pkg::SUM_WIDTH-1:0]  den,
    output logic                                  out_valid,
    output rpi_pkg::ray_t                         ray_out,
    output rpi_pkg::div_flags_t                   flags,
    output logic [rpi_pkg::COORD_WIDTH-1:0]       quo
);

    localparam int STEPS = rpi_pkg::COORD_WIDTH;

    logic [rpi_pkg::SUM_WIDTH-1:0] anum;
    logic [rpi_pkg::SUM_WIDTH-1:0] aden;
    logic [rpi_pkg::NUM_WIDTH-1:0] nfull;
    rpi_pkg::div_flags_t           flags_next;
    rpi_pkg::div_state_t           init_next;

    logic                          valid_reg [0:STEPS];
    rpi_pkg::ray_t                 ray_reg   [0:STEPS];
    rpi_pkg::div_flags_t           flags_reg [0:STEPS];
    rpi_pkg::div_state_t           st_reg    [0:STEPS];

    function automatic rpi_pkg::div_state_t div_step(rpi_pkg::div_state_t s);
        logic [rpi_pkg::REM_WIDTH-1:0] t;
        logic                          ge;
        rpi_pkg::div_state_t           r;
        t  = {s.rem[rpi_pkg::REM_WIDTH-2:0], s.quo[rpi_pkg::COORD_WIDTH-1]};
        ge = t >= rpi_pkg::REM_WIDTH'(s.dvsr);
        r.rem  = ge ? t - rpi_pkg::REM_WIDTH'(s.dvsr) : t;
        r.dvsr = s.dvsr;
        r.quo  = {s.quo[rpi_pkg::COORD_WIDTH-2:0], ge};
        return r;
    endfunction

    always_comb
    begin
        anum  = num[rpi_pkg::SUM_WIDTH-1] ? rpi_pkg::SUM_WIDTH'(-num)
                                          : rpi_pkg::SUM_WIDTH'(num);
        aden  = den[rpi_pkg::SUM_WIDTH-1] ? rpi_pkg::SUM_WIDTH'(-den)
                                          : rpi_pkg::SUM_WIDTH'(den);
        nfull = {anum, {rpi_pkg::FRAC_BITS{1'b0}}};
        flags_next.parallel = (den == '0);
        flags_next.neg      = (num != '0) && (num[rpi_pkg::SUM_WIDTH-1]
                                              != den[rpi_pkg::SUM_WIDTH-1]);
        // The quotient cannot fit when the dividend's upper part reaches the divisor.
        flags_next.big = rpi_pkg::NUM_WIDTH'(nfull[rpi_pkg::NUM_WIDTH-1:rpi_pkg::COORD_WIDTH])
                         >= rpi_pkg::NUM_WIDTH'(aden);
        init_next.rem  = rpi_pkg::REM_WIDTH'(nfull >> rpi_pkg::COORD_WIDTH);
        init_next.dvsr = aden;
        init_next.quo  = nfull[rpi_pkg::COORD_WIDTH-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        ray_reg[0]   <= ray;
        flags_reg[0] <= flags_next;
        st_reg[0]    <= init_next;
    end

    for (genvar k = 1; k <= STEPS; k++)
    begin : g_step
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            ray_reg[k]   <= ray_reg[k-1];
            flags_reg[k] <= flags_reg[k-1];
            st_reg[k]    <= div_step(st_reg[k-1]);
        end
    end

    assign out_valid = valid_reg[STEPS];
    assign ray_out   = ray_reg[STEPS];
    assign flags     = flags_reg[STEPS];
    assign quo       = st_reg[STEPS].quo;

endmodule

[sv/rpi_hit.sv]
// Hit point stages: ray parameter saturation, direction products, origin add and
// coordinate saturation. Depends on rpi_pkg.
module rpi_hit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  rpi_pkg::ray_t                   ray,
    input  rpi_pkg::div_flags_t             flags,
    input  logic [rpi_pkg::COORD_WIDTH-1:0] quo,
    output logic                            out_valid,
    output rpi_pkg::result_t                result
);

    localparam int W = rpi_pkg::COORD_WIDTH;
    localparam logic signed [rpi_pkg::HIT_WIDTH-1:0] HIT_MAX =
        rpi_pkg::HIT_WIDTH'({1'b0, {(W-1){1'b1}}});
    localparam logic signed [rpi_pkg::HIT_WIDTH-1:0] HIT_MIN = -HIT_MAX - 1;

    logic [W-1:0]                          maxq;
    logic                                  lam_ov;
    logic [W-1:0]                          qsat;
    rpi_pkg::coord_t                       lam_next;

    logic                                  a_valid_reg;
    rpi_pkg::ray_t                         a_ray_reg;
    rpi_pkg::div_flags_t                   a_flags_reg;
    logic                                  a_ov_reg;
    rpi_pkg::coord_t                       a_lam_reg;

    logic                                  b_valid_reg;
    rpi_pkg::ray_t                         b_ray_reg;
    rpi_pkg::div_flags_t                   b_flags_reg;
    logic                                  b_ov_reg;
    logic signed [rpi_pkg::PROD_WIDTH-1:0] b_prod_reg [0:2];

    logic signed [rpi_pkg::HIT_WIDTH-1:0]  sum [0:2];
    rpi_pkg::coord_t                       org [0:2];
    rpi_pkg::coord_t                       hit [0:2];
    logic [2:0]                            hit_ov;
    rpi_pkg::result_t                      result_next;

    logic                                  c_valid_reg;
    rpi_pkg::result_t                      result_reg;

    always_comb
    begin
        maxq     = flags.neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        lam_ov   = flags.big || (quo > maxq);
        qsat     = lam_ov ? maxq : quo;
        lam_next = flags.neg ? rpi_pkg::coord_t'(-qsat) : rpi_pkg::coord_t'(qsat);
    end

    always_comb
    begin
        org[0] = b_ray_reg.ray_origin_x;
        org[1] = b_ray_reg.ray_origin_y;
        org[2] = b_ray_reg.ray_origin_z;
        for (int i = 0; i < 3; i++)
        begin
            sum[i] = rpi_pkg::HIT_WIDTH'(b_prod_reg[i] >>> rpi_pkg::FRAC_BITS)
                     + rpi_pkg::HIT_WIDTH'(org[i]);
            hit_ov[i] = (sum[i] > HIT_MAX) || (sum[i] < HIT_MIN);
            if (sum[i] > HIT_MAX)
            begin
                hit[i] = rpi_pkg::coord_t'(HIT_MAX);
            end
            else if (sum[i] < HIT_MIN)
            begin
                hit[i] = rpi_pkg::coord_t'(HIT_MIN);
            end
            else
            begin
                hit[i] = rpi_pkg::coord_t'(sum[i]);
            end
        end
        if (b_flags_reg.parallel)
        begin
            result_next.hit_x       = org[0];
            result_next.hit_y       = org[1];
            result_next.hit_z       = org[2];
            result_next.is_parallel = 1'b1;
            result_next.is_behind   = 1'b0;
            result_next.overflowed  = 1'b0;
        end
        else
        begin
            result_next.hit_x       = hit[0];
            result_next.hit_y       = hit[1];
            result_next.hit_z       = hit[2];
            result_next.is_parallel = 1'b0;
            result_next.is_behind   = b_flags_reg.neg;
            result_next.overflowed  = b_ov_reg || (hit_ov != '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_ray_reg     <= ray;
        a_flags_reg   <= flags;
        a_ov_reg      <= lam_ov;
        a_lam_reg     <= lam_next;
        b_ray_reg     <= a_ray_reg;
        b_flags_reg   <= a_flags_reg;
        b_ov_reg      <= a_ov_reg;
        b_prod_reg[0] <= rpi_pkg::smul(a_ray_reg.ray_dir_x, a_lam_reg);
        b_prod_reg[1] <= rpi_pkg::smul(a_ray_reg.ray_dir_y, a_lam_reg);
        b_prod_reg[2] <= rpi_pkg::smul(a_ray_reg.ray_dir_z, a_lam_reg);
        result_reg    <= result_next;
    end

    assign out_valid = c_valid_reg;
    assign result    = result_reg;

endmodule

[sim/testbench.sv]
// Testbench for ray_plane_intersection_unit: random and directed rays are checked
// against an in-bench fixed-point predictor. Depends on rpi_pkg and the unit itself.
`timescale 1ns / 1ps
module testbench;

    localparam int WIDE = 168;
    localparam int STALL_LIMIT = 4000;
    localparam logic [rpi_pkg::CFG_IDX_WIDTH-1:0] REG_SPARE_A = 3'd6;
    localparam logic [rpi_pkg::CFG_IDX_WIDTH-1:0] REG_SPARE_B = 3'd7;
    localparam rpi_pkg::coord_t MAX_C = 32'sh7fffffff;
    localparam rpi_pkg::coord_t MIN_C = 32'sh80000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    rpi_pkg::ray_t ray = '0;
    logic done;
    rpi_pkg::result_t result;
    logic cfg_we = 1'b0;
    logic [rpi_pkg::CFG_IDX_WIDTH-1:0] cfg_index = '0;
    logic [rpi_pkg::COORD_WIDTH-1:0] cfg_data = '0;

    rpi_pkg::ray_t pending_rays[$];
    rpi_pkg::result_t expected_hits[$];
    rpi_pkg::plane_t plane_model;
    int idle_pct = 0;
    int error_count = 0;
    int stall_count = 0;
    bit took = 1'b0;

    ray_plane_intersection_unit dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .ray(ray),
        .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    function automatic rpi_pkg::coord_t clamp_coord(logic signed [WIDE-1:0] v, ref bit ov);
        if (v > WIDE'(MAX_C))
        begin
            ov = 1'b1;
            return MAX_C;
        end
        if (v < WIDE'(MIN_C))
        begin
            ov = 1'b1;
            return MIN_C;
        end
        return rpi_pkg::coord_t'(v);
    endfunction

    function automatic rpi_pkg::result_t predict_hit(rpi_pkg::ray_t r, rpi_pkg::plane_t pl);
        logic signed [WIDE-1:0] o[3], d[3], p[3], n[3], den, num, lam, t;
        logic [WIDE-1:0] abs_num, abs_den, quo, max_q;
        bit neg_q, ov;
        rpi_pkg::result_t res;
        o[0] = r.ray_origin_x; o[1] = r.ray_origin_y; o[2] = r.ray_origin_z;
        d[0] = r.ray_dir_x; d[1] = r.ray_dir_y; d[2] = r.ray_dir_z;
        p[0] = pl.point_x; p[1] = pl.point_y; p[2] = pl.point_z;
        n[0] = pl.normal_x; n[1] = pl.normal_y; n[2] = pl.normal_z;
        if (n[0] == 0 && n[1] == 0 && n[2] == 0)
            n[0] = WIDE'(1) <<< rpi_pkg::FRAC_BITS;
        den = '0;
        num = '0;
        for (int i = 0; i < 3; i++)
        begin
            den = den + n[i] * d[i];
            num = num + p[i] * n[i] - n[i] * o[i];
        end
        res = '0;
        if (den == 0)
        begin
            res.hit_x = r.ray_origin_x;
            res.hit_y = r.ray_origin_y;
            res.hit_z = r.ray_origin_z;
            res.is_parallel = 1'b1;
            return res;
        end
        neg_q = (num != 0) && ((num < 0) != (den < 0));
        ov = 1'b0;
        abs_num = (num < 0) ? -num : num;
        abs_den = (den < 0) ? -den : den;
        quo = (abs_num << rpi_pkg::FRAC_BITS) / abs_den;
        max_q = (WIDE'(1) << (rpi_pkg::COORD_WIDTH - 1)) - WIDE'(neg_q ? 0 : 1);
        if (quo > max_q)
        begin
            ov = 1'b1;
            quo = max_q;
        end
        lam = neg_q ? -$signed(quo) : $signed(quo);
        t = ((d[0] * lam) >>> rpi_pkg::FRAC_BITS) + o[0];
        res.hit_x = clamp_coord(t, ov);
        t = ((d[1] * lam) >>> rpi_pkg::FRAC_BITS) + o[1];
        res.hit_y = clamp_coord(t, ov);
        t = ((d[2] * lam) >>> rpi_pkg::FRAC_BITS) + o[2];
        res.hit_z = clamp_coord(t, ov);
        res.is_behind = neg_q;
        res.overflowed = ov;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch on %s at %0t: got %h, want %h", what, $realtime, got, want);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        rpi_pkg::result_t want;
        took = start && !busy;
        if (took)
            expected_hits.push_back(predict_hit(ray, plane_model));
        if (done)
        begin
            if (expected_hits.size() == 0)
                report_mismatch("unexpected result", 64'(result.hit_x), 64'(0));
            else
            begin
                want = expected_hits.pop_front();
                if (result.hit_x !== want.hit_x)
                    report_mismatch("hit_x", 64'(result.hit_x), 64'(want.hit_x));
                if (result.hit_y !== want.hit_y)
                    report_mismatch("hit_y", 64'(result.hit_y), 64'(want.hit_y));
                if (result.hit_z !== want.hit_z)
                    report_mismatch("hit_z", 64'(result.hit_z), 64'(want.hit_z));
                if (result.is_parallel !== want.is_parallel)
                    report_mismatch("is_parallel", 64'(result.is_parallel),
                                    64'(want.is_parallel));
                if (result.is_behind !== want.is_behind)
                    report_mismatch("is_behind", 64'(result.is_behind),
                                    64'(want.is_behind));
                if (result.overflowed !== want.overflowed)
                    report_mismatch("overflowed", 64'(result.overflowed),
                                    64'(want.overflowed));
            end
        end
        if (took || done || (pending_rays.size() == 0 && expected_hits.size() == 0))
            stall_count = 0;
        else
            stall_count++;
        if (stall_count >= STALL_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (start && !took)
            start <= 1'b1;
        else if (pending_rays.size() != 0 && $urandom_range(99) >= idle_pct)
        begin
            start <= 1'b1;
            ray <= pending_rays.pop_front();
        end
        else
            start <= 1'b0;
    end

    function automatic rpi_pkg::coord_t pick_coord();
        case ($urandom_range(9))
            0: return MAX_C;
            1: return MIN_C;
            2: return '0;
            3, 4, 5: return rpi_pkg::coord_t'($signed($urandom_range(2097152)) - 1048576);
            default: return rpi_pkg::coord_t'($urandom);
        endcase
    endfunction

    function automatic rpi_pkg::ray_t pick_ray();
        rpi_pkg::ray_t r;
        r.ray_origin_x = pick_coord();
        r.ray_origin_y = pick_coord();
        r.ray_origin_z = pick_coord();
        r.ray_dir_x = pick_coord();
        r.ray_dir_y = pick_coord();
        r.ray_dir_z = pick_coord();
        case ($urandom_range(7))
            0: {r.ray_dir_x, r.ray_dir_y, r.ray_dir_z} = '0;
            1:
            begin
                r.ray_dir_x = plane_model.normal_y;
                r.ray_dir_y = -plane_model.normal_x;
                r.ray_dir_z = '0;
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic rpi_pkg::ray_t make_ray(rpi_pkg::coord_t ox, rpi_pkg::coord_t oy,
                                               rpi_pkg::coord_t oz, rpi_pkg::coord_t dx,
                                               rpi_pkg::coord_t dy, rpi_pkg::coord_t dz);
        rpi_pkg::ray_t r;
        r = '{ox, oy, oz, dx, dy, dz};
        return r;
    endfunction

    task automatic write_reg(logic [rpi_pkg::CFG_IDX_WIDTH-1:0] idx, rpi_pkg::coord_t value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            rpi_pkg::REG_POINT_X: plane_model.point_x = value;
            rpi_pkg::REG_POINT_Y: plane_model.point_y = value;
            rpi_pkg::REG_POINT_Z: plane_model.point_z = value;
            rpi_pkg::REG_NORMAL_X: plane_model.normal_x = value;
            rpi_pkg::REG_NORMAL_Y: plane_model.normal_y = value;
            rpi_pkg::REG_NORMAL_Z: plane_model.normal_z = value;
            default: ;
        endcase
    endtask

    task automatic load_plane(rpi_pkg::coord_t px, rpi_pkg::coord_t py, rpi_pkg::coord_t pz,
                              rpi_pkg::coord_t nx, rpi_pkg::coord_t ny, rpi_pkg::coord_t nz);
        write_reg(rpi_pkg::REG_POINT_X, px);
        write_reg(rpi_pkg::REG_POINT_Y, py);
        write_reg(rpi_pkg::REG_POINT_Z, pz);
        write_reg(rpi_pkg::REG_NORMAL_X, nx);
        write_reg(rpi_pkg::REG_NORMAL_Y, ny);
        write_reg(rpi_pkg::REG_NORMAL_Z, nz);
        write_reg(REG_SPARE_A, rpi_pkg::coord_t'($urandom));
        write_reg(REG_SPARE_B, rpi_pkg::coord_t'($urandom));
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        wait (pending_rays.size() == 0 && expected_hits.size() == 0 && !start);
        repeat (rpi_pkg::COORD_WIDTH + 12) @(negedge clk);
    endtask

    initial
    begin
        int idle_plan[4];
        rpi_pkg::coord_t one;
        idle_plan = '{0, 77, 77, 38};
        one = rpi_pkg::UNIT_COORD;
        plane_model = '{0, 0, 0, rpi_pkg::UNIT_COORD, 0, 0};
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        pending_rays.push_back(make_ray(0, 0, 0, 0, 0, 0));
        pending_rays.push_back(make_ray(5 * one, 1, 2, 0, one, -one));
        pending_rays.push_back(make_ray(-3 * one, 0, 0, one, 0, 0));
        pending_rays.push_back(make_ray(3 * one, 0, 0, one, 0, 0));
        pending_rays.push_back(make_ray(-3 * one, one, one, -one, 2 * one, 0));
        pending_rays.push_back(make_ray(MIN_C, MAX_C, MIN_C, 1, 0, 0));
        pending_rays.push_back(make_ray(MAX_C, MIN_C, MAX_C, MIN_C, MAX_C, MIN_C));
        pending_rays.push_back(make_ray(MIN_C, MIN_C, MIN_C, MAX_C, MAX_C, MAX_C));
        pending_rays.push_back(make_ray(MAX_C, MAX_C, MAX_C, MAX_C, MIN_C, MAX_C));
        pending_rays.push_back(make_ray(one, 0, 0, MAX_C, MAX_C, MIN_C));
        pending_rays.push_back(make_ray(-one, 0, 0, 3, 7 * one, 0));
        pending_rays.push_back(make_ray(7, 0, 0, -3, 0, 0));
        pending_rays.push_back(make_ray(-1, -1, -1, -1, -1, -1));
        drain();
        load_plane(0, 0, 0, 0, 0, 0);
        pending_rays.push_back(make_ray(-2 * one, 0, 0, one, one, one));
        pending_rays.push_back(make_ray(2 * one, one, 0, 0, one, 0));
        pending_rays.push_back(make_ray(MAX_C, 0, 0, MIN_C, 0, 0));
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: load_plane(MAX_C, MAX_C, MAX_C, MAX_C, MAX_C, MAX_C);
                1: load_plane(MIN_C, MIN_C, MIN_C, MIN_C, MIN_C, MIN_C);
                2: load_plane(one, 2 * one, -one, 0, one, 0);
                3: load_plane(0, 0, 0, 0, 0, 0);
                4: load_plane(pick_coord(), pick_coord(), pick_coord(), 0, 0, -one);
                default: load_plane(pick_coord(), pick_coord(), pick_coord(),
                                    pick_coord(), pick_coord(), pick_coord());
            endcase
            idle_pct = idle_plan[ph % 4];
            for (int k = 0; k < 180; k++)
                pending_rays.push_back(pick_ray());
            drain();
            idle_pct = 0;
        end

        if (error_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end
endmodule
